### design/dtt_pkg.sv
// Shared types and codes of the divider and counter timer.
`default_nettype none
package dtt_pkg;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SEL_DIV  = 2'd0,
      SEL_CNT  = 2'd1,
      SEL_MOD  = 2'd2,
      SEL_CTRL = 2'd3
   } reg_sel_type;

   typedef struct packed {
      mode_type    mode;
      reg_sel_type reg_select;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       irq;
   } rsp_type;

endpackage
`default_nettype wire

### design/dtt_core.sv
// Timer state registers and the per-beat update of divider, counter, modulo and control.
`default_nettype none
module dtt_core
   import dtt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   output rsp_type      result
);

   localparam logic [7:0] CtrlReadOnes = 8'hF8;
   localparam int         DivShift     = 6;

   logic [15:0] sys_ff,   sys_in;
   logic [7:0]  cnt_ff,   cnt_in;
   logic [7:0]  mod_ff,   mod_in;
   logic [2:0]  ctrl_ff,  ctrl_in;
   logic        pend_ff,  pend_in;
   logic        done_ff,  done_in;
   logic        wrote_ff, wrote_in;

   logic [7:0]  cnt_base;
   logic        pend_base;
   logic        bump;
   logic        old_bit;
   logic        new_bit;
   logic [15:0] sys_inc;

   // Rates 0..3 watch system counter bits 7, 1, 3 and 5.
   function automatic logic sel_bit(input logic [15:0] sys, input logic [1:0] rate);
      logic b;
      case (rate)
         2'd0:    b = sys[7];
         2'd1:    b = sys[1];
         2'd2:    b = sys[3];
         default: b = sys[5];
      endcase
      return b;
   endfunction

   assign sys_inc = sys_ff + 16'd1;
   assign old_bit = sel_bit(sys_ff, ctrl_ff[1:0]);
   assign new_bit = sel_bit(sys_ff, item.wdata[1:0]);

   always_comb begin
      sys_in    = sys_ff;
      cnt_base  = cnt_ff;
      mod_in    = mod_ff;
      ctrl_in   = ctrl_ff;
      pend_base = pend_ff;
      done_in   = done_ff;
      wrote_in  = wrote_ff;
      bump      = 1'b0;
      result    = '0;
      case (item.mode)
         MODE_TICK: begin
            // A pending overflow reloads now unless the counter was written meanwhile.
            done_in   = pend_ff;
            pend_base = 1'b0;
            wrote_in  = 1'b0;
            if (pend_ff && !wrote_ff) begin
               cnt_base   = mod_ff;
               result.irq = 1'b1;
            end
            sys_in = sys_inc;
            bump   = ctrl_ff[2] && old_bit && !sel_bit(sys_inc, ctrl_ff[1:0]);
         end
         MODE_READ: begin
            case (item.reg_select)
               SEL_DIV:  result.rdata = sys_ff[DivShift +: 8];
               SEL_CNT:  result.rdata = cnt_ff;
               SEL_MOD:  result.rdata = mod_ff;
               default:  result.rdata = CtrlReadOnes | {5'd0, ctrl_ff};
            endcase
         end
         MODE_WRITE: begin
            case (item.reg_select)
               SEL_DIV: begin
                  // Clearing the divider is a falling edge when the watched bit was set.
                  sys_in = '0;
                  bump   = ctrl_ff[2] && old_bit;
               end
               SEL_CNT: begin
                  if (!done_ff) begin
                     wrote_in = 1'b1;
                     cnt_base = item.wdata;
                  end
               end
               SEL_MOD: begin
                  mod_in = item.wdata;
                  if (done_ff) begin
                     cnt_base = item.wdata;
                  end
               end
               default: begin
                  // Disabling or switching rate can produce a glitch edge.
                  bump    = (ctrl_ff[2] && !item.wdata[2] && old_bit) || (old_bit && !new_bit);
                  ctrl_in = item.wdata[2:0];
               end
            endcase
         end
         default: begin
         end
      endcase
      cnt_in  = bump ? cnt_base + 8'd1 : cnt_base;
      pend_in = pend_base || (bump && (cnt_base == 8'hFF));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_ff   <= '0;
         cnt_ff   <= '0;
         mod_ff   <= '0;
         ctrl_ff  <= '0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         wrote_ff <= 1'b0;
      end else if (step) begin
         sys_ff   <= sys_in;
         cnt_ff   <= cnt_in;
         mod_ff   <= mod_in;
         ctrl_ff  <= ctrl_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
         wrote_ff <= wrote_in;
      end
   end

endmodule
`default_nettype wire

### design/div_tima_timer.sv
// Top level of the divider and counter timer with its beat pipeline.
// An accepted request beat passes through stage one and then the response register.
// Throughput: one request beat per cycle while rsp_stall is low, set by the single-pass core.
// Stalls on the response side back up through one request register and then req_stall.
// Reset (synchronous, active high) clears all timer state and empties both stages.
`default_nettype none
module div_tima_timer
   import dtt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Stage one holds the accepted request beat; the response register holds its result.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic    out_free;
   logic    s1_go;
   logic    accept;
   rsp_type core_result;

   // The response register can take a new result when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && rsp_stall);

   // Timer state advances exactly when a beat moves from stage one into the response register,
   // so the state sees beats in acceptance order, once each.
   dtt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_go),
      .item   (s1_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
      if (s1_go) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Stalling the request side only makes sense when both stages are occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with an empty stage");

   // A beat leaving stage one always lands in the response register.
   a_go_lands: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("advanced beat lost");

   // A held beat in stage one is not dropped.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> s1_valid_ff)
      else $error("held request beat dropped");

   // An interrupt comes only from a tick, which never returns read data.
   a_irq_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.irq) |-> (rsp_ff.rdata == 8'd0))
      else $error("interrupt beat carries read data");

endmodule
`default_nettype wire

### verif/dtt_checker.sv
`timescale 1ns / 100ps
// Checker for the divider and counter timer: predicts each response beat and compares it.
module dtt_checker
   import dtt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      due_count
);

   localparam int         ENABLE_BIT     = 2;
   localparam int         DIV_LSB        = 6;
   localparam logic [7:0] CTRL_READ_FILL = 8'hF8;

   // Shadow copy of the timer state.
   logic [15:0] div_counter;
   logic [7:0]  timer_count;
   logic [7:0]  timer_modulo;
   logic [2:0]  timer_control;
   logic        overflow_pending;
   logic        reloaded_last;
   logic        count_overwritten;

   rsp_type     rsp_due[$];
   rsp_type     oldest_due;

   initial begin
      fail_count = 0;
      due_count  = 0;
   end

   task automatic flag_mismatch(input string msg);
      $display("[%0t] timer mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Bit of the system counter whose falling edge clocks the counter at each rate.
   function automatic int rate_bit(input logic [1:0] rate);
      case (rate)
         2'd0:    return 7;
         2'd1:    return 1;
         2'd2:    return 3;
         default: return 5;
      endcase
   endfunction

   function automatic void bump_count();
      timer_count = timer_count + 8'd1;
      if (timer_count == 8'd0)
         overflow_pending = 1'b1;
   endfunction

   // Any change of the system counter can produce a falling edge on the selected bit.
   function automatic void move_divider(input logic [15:0] next_value);
      int sel;
      sel = rate_bit(timer_control[1:0]);
      if (timer_control[ENABLE_BIT] && div_counter[sel] && !next_value[sel])
         bump_count();
      div_counter = next_value;
   endfunction

   function automatic rsp_type timer_advance(input req_type beat);
      rsp_type result;
      logic    old_sel;
      logic    new_sel;
      result = '0;
      case (beat.mode)
         MODE_TICK: begin
            reloaded_last = 1'b0;
            if (overflow_pending) begin
               overflow_pending = 1'b0;
               reloaded_last    = 1'b1;
               if (!count_overwritten) begin
                  timer_count = timer_modulo;
                  result.irq  = 1'b1;
               end
            end
            count_overwritten = 1'b0;
            move_divider(div_counter + 16'd1);
         end
         MODE_READ: begin
            case (beat.reg_select)
               SEL_DIV: result.rdata = div_counter[DIV_LSB +: 8];
               SEL_CNT: result.rdata = timer_count;
               SEL_MOD: result.rdata = timer_modulo;
               default: result.rdata = CTRL_READ_FILL | {5'd0, timer_control};
            endcase
         end
         MODE_WRITE: begin
            case (beat.reg_select)
               SEL_DIV: move_divider(16'd0);
               SEL_CNT: begin
                  if (!reloaded_last) begin
                     count_overwritten = 1'b1;
                     timer_count       = beat.wdata;
                  end
               end
               SEL_MOD: begin
                  timer_modulo = beat.wdata;
                  if (reloaded_last)
                     timer_count = beat.wdata;
               end
               default: begin
                  old_sel = div_counter[rate_bit(timer_control[1:0])];
                  new_sel = div_counter[rate_bit(beat.wdata[1:0])];
                  if (timer_control[ENABLE_BIT] && !beat.wdata[ENABLE_BIT] && old_sel)
                     bump_count();
                  else if (old_sel && !new_sel)
                     bump_count();
                  timer_control = beat.wdata[2:0];
               end
            endcase
         end
         default: ;
      endcase
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         div_counter       = '0;
         timer_count       = '0;
         timer_modulo      = '0;
         timer_control     = '0;
         overflow_pending  = 1'b0;
         reloaded_last     = 1'b0;
         count_overwritten = 1'b0;
         rsp_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               flag_mismatch($sformatf("response beat with none pending, rdata=%02h irq=%b",
                                       rsp_data.rdata, rsp_data.irq));
            end else begin
               oldest_due = rsp_due.pop_front();
               if (rsp_data.rdata !== oldest_due.rdata)
                  flag_mismatch($sformatf("rdata %02h, predicted %02h",
                                          rsp_data.rdata, oldest_due.rdata));
               if (rsp_data.irq !== oldest_due.irq)
                  flag_mismatch($sformatf("irq %b, predicted %b",
                                          rsp_data.irq, oldest_due.irq));
            end
         end
         if (req_valid && !req_stall)
            rsp_due.push_back(timer_advance(req_data));
      end
      due_count = rsp_due.size();
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the timer testbench: clock, reset, request and response stimulus, and the verdict.
module tb_top;
   import dtt_pkg::*;

   // The mode field is two bits wide, so the one code the block leaves unused
   // must be exercised too. It should behave as a no-op with a zero response.
   localparam mode_type MODE_SPARE = mode_type'(2'd3);

   localparam int ITEM_TARGET  = 1700;
   // Items at the end of the run that go through with no idling on either side.
   localparam int QUIET_TAIL   = 250;
   localparam int DRAIN_LIMIT  = 2000;
   // Extra cycles after the drain, so that a stray response beat would still be seen.
   localparam int DRAIN_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int      fail_count;
   int      due_count;
   int      beats_sent = 0;
   int      stall_left = 0;
   // When clear, neither the sender nor the receiver inserts idle cycles.
   bit      idle_on    = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   div_tima_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dtt_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .due_count  (due_count)
   );

   // The receiver stalls in bursts. A burst can start on any cycle, so stalls
   // land on every stage of the pipeline and also back up into req_stall.
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type beat_of(input mode_type m, input reg_sel_type s,
                                       input logic [7:0] d);
      req_type b;
      b.mode       = m;
      b.reg_select = s;
      b.wdata      = d;
      return b;
   endfunction

   // Noise beat: any mode, the spare one now and then, any register, any data.
   function automatic req_type any_beat();
      mode_type m;
      if ($urandom_range(0, 7) == 0)
         m = MODE_SPARE;
      else
         m = mode_type'($urandom_range(0, 2));
      return beat_of(m, reg_sel_type'($urandom_range(0, 3)), 8'($urandom));
   endfunction

   // Drives one request beat and returns at the falling edge after it was taken.
   // The task is always entered at a falling edge. Valid stays high from one beat
   // to the next unless a sender gap is inserted first.
   task automatic send_beat(input req_type b);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // Run limit, far beyond the slowest legal run with the longest gaps and stalls.
   initial begin
      #(5_000_000);
      $display("[div_tima_timer] ERROR");
      $finish;
   end

   initial begin
      logic [7:0] ctrl_byte;
      int         run_length;
      int         waited;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Reads of every register straight out of reset, then a
      // walk through the reload quirks at the fastest rate (system bit 1).
      send_beat(beat_of(MODE_READ, SEL_DIV, 8'h00));
      send_beat(beat_of(MODE_READ, SEL_CNT, 8'hFF));
      send_beat(beat_of(MODE_READ, SEL_MOD, 8'h00));
      send_beat(beat_of(MODE_READ, SEL_CTRL, 8'hFF));
      send_beat(beat_of(MODE_WRITE, SEL_MOD, 8'hA5));
      // Control upper bits are set on purpose; only the low three should stick.
      send_beat(beat_of(MODE_WRITE, SEL_CTRL, 8'hFD));
      send_beat(beat_of(MODE_WRITE, SEL_CNT, 8'hFF));
      send_beat(beat_of(MODE_TICK, SEL_DIV, 8'h00));
      send_beat(beat_of(MODE_TICK, SEL_CTRL, 8'hFF));
      // The selected bit is high now, so clearing the divider is a falling edge:
      // the counter wraps and a reload is pending.
      send_beat(beat_of(MODE_WRITE, SEL_DIV, 8'h5A));
      // Reload tick with the interrupt.
      send_beat(beat_of(MODE_TICK, SEL_CNT, 8'h00));
      // In the reload cycle a counter write is dropped, and a modulo write
      // goes through to the counter as well.
      send_beat(beat_of(MODE_WRITE, SEL_CNT, 8'h12));
      send_beat(beat_of(MODE_WRITE, SEL_MOD, 8'h3C));
      send_beat(beat_of(MODE_READ, SEL_CNT, 8'h00));
      send_beat(beat_of(MODE_WRITE, SEL_CNT, 8'hFF));
      send_beat(beat_of(MODE_TICK, SEL_MOD, 8'h00));
      // Rate change from bit 1 (high) to bit 7 (low) is a glitch increment;
      // the counter holds the reloaded modulo here, so it does not wrap.
      send_beat(beat_of(MODE_WRITE, SEL_CTRL, 8'h04));
      // A counter write before the reload tick would cancel the reload and its interrupt; here none is pending.
      send_beat(beat_of(MODE_WRITE, SEL_CNT, 8'h00));
      send_beat(beat_of(MODE_TICK, SEL_DIV, 8'hFF));
      send_beat(beat_of(MODE_READ, SEL_CNT, 8'h00));
      // Back to bit 1, then disabling while that bit is high also increments.
      send_beat(beat_of(MODE_WRITE, SEL_CTRL, 8'h05));
      send_beat(beat_of(MODE_WRITE, SEL_CTRL, 8'h01));
      send_beat(beat_of(MODE_READ, SEL_CTRL, 8'h00));
      send_beat(beat_of(MODE_SPARE, SEL_CNT, 8'hFF));
      send_beat(beat_of(MODE_READ, SEL_DIV, 8'h00));

      // Random part, built from episodes: set up the control, modulo and a
      // counter close to overflow, then run mostly ticks with noise mixed in.
      // Most control settings keep the timer enabled so that overflows, reload
      // ticks and writes that land in the reload cycle come up often.
      while (beats_sent < ITEM_TARGET) begin
         if (beats_sent >= ITEM_TARGET - QUIET_TAIL)
            idle_on <= 1'b0;
         else
            idle_on <= ($urandom_range(0, 3) != 0);

         ctrl_byte = 8'($urandom);
         if ($urandom_range(0, 3) != 0)
            ctrl_byte[2] = 1'b1;
         send_beat(beat_of(MODE_WRITE, SEL_CTRL, ctrl_byte));
         if ($urandom_range(0, 1) == 0)
            send_beat(beat_of(MODE_WRITE, SEL_MOD, 8'($urandom)));
         if ($urandom_range(0, 3) != 0)
            send_beat(beat_of(MODE_WRITE, SEL_CNT, 8'($urandom_range(248, 255))));
         else
            send_beat(beat_of(MODE_WRITE, SEL_CNT, 8'($urandom)));

         run_length = $urandom_range(4, 48);
         repeat (run_length) begin
            if ($urandom_range(0, 99) < 65)
               send_beat(beat_of(MODE_TICK, reg_sel_type'($urandom_range(0, 3)),
                                 8'($urandom)));
            else
               send_beat(any_beat());
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every predicted response beat, bounded, then a few
      // more cycles so that an extra beat from the block would still be seen.
      waited = 0;
      while (due_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && due_count == 0)
         $display("[div_tima_timer] OK");
      else
         $display("[div_tima_timer] ERROR");
      $finish;
   end

endmodule

### files.f
design/dtt_pkg.sv
design/dtt_core.sv
design/div_tima_timer.sv
verif/dtt_checker.sv
verif/tb_top.sv
